// ===== rtl/spi_multi_slave_poll_sequencer_core_defines.svh =====
// Assertion macros used by the checker file of the poll sequencer core.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef SPI_MULTI_SLAVE_POLL_SEQUENCER_CORE_DEFINES_SVH
`define SPI_MULTI_SLAVE_POLL_SEQUENCER_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SPMS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spms check failed in the same cycle");

// Check that a condition implies another in the following cycle.
`define SPMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spms check failed one cycle later");

`endif

// ===== rtl/spms_pkg.sv =====
// Shared types, codes and constants of the SPI multi-slave poll sequencer.
// Used by every module of the block but spms_ram; depends on nothing.
`timescale 1ns / 1ps

package spms_pkg;

  // Default sizes handed to the top-level parameters
  localparam int BUFFER_DEPTH_DEF = 256;
  localparam int SLAVE_COUNT_DEF  = 4;

  // Generation tag kept next to each transmit store byte
  localparam int GEN_W = 12;

  localparam logic [7:0] ABORT_BYTE = 8'hFF;

  // Request operation codes
  localparam logic [1:0] OP_ADVANCE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RX      = 2'd2;
  localparam logic [1:0] OP_LOAD    = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_TRANSFER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_DELAY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DELAY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_DELAY          = 3'd5;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [8:0]  BYTES_PER_TRANSFER_RST = 9'd250;
  localparam logic [1:0]  RETRY_LIMIT_RST        = 2'd3;
  localparam logic [15:0] SELECT_DELAY_RST       = 16'd1;
  localparam logic [15:0] RETRY_DELAY_RST        = 16'd2;
  localparam logic [15:0] RELEASE_DELAY_RST      = 16'd1;
  localparam logic [15:0] GAP_DELAY_RST          = 16'd11;

  // Phase codes as shown on the result
  localparam logic [2:0] PH_CODE_SELECT  = 3'd0;
  localparam logic [2:0] PH_CODE_WAIT    = 3'd1;
  localparam logic [2:0] PH_CODE_SEND    = 3'd2;
  localparam logic [2:0] PH_CODE_RELEASE = 3'd3;
  localparam logic [2:0] PH_CODE_FINISH  = 3'd4;
  localparam logic [2:0] PH_CODE_DELAY   = 3'd5;

  typedef enum logic [5:0] {
    PH_SELECT  = 6'b000001,
    PH_WAIT    = 6'b000010,
    PH_SEND    = 6'b000100,
    PH_RELEASE = 6'b001000,
    PH_FINISH  = 6'b010000,
    PH_DELAY   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [7:0] load_index;
    logic [7:0] load_value;
  } req_item_t;

  typedef struct packed {
    logic [3:0] chip_select_n;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       push_valid;
    logic [7:0] push_byte;
    logic [2:0] phase;
    logic [1:0] current_slave;
  } rsp_item_t;

  typedef struct packed {
    logic [8:0]  bytes_per_transfer;
    logic [1:0]  retry_limit;
    logic [15:0] select_delay;
    logic [15:0] retry_delay;
    logic [15:0] release_delay;
    logic [15:0] gap_delay;
  } cfg_t;

  // Transmit store access requested by the sequencer for one request
  typedef struct packed {
    logic       load_en;
    logic [7:0] load_index;
    logic [7:0] load_value;
    logic       read_en;
    logic [8:0] read_pos;
    logic       clear;
  } store_req_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_SELECT:  code = PH_CODE_SELECT;
      PH_WAIT:    code = PH_CODE_WAIT;
      PH_SEND:    code = PH_CODE_SEND;
      PH_RELEASE: code = PH_CODE_RELEASE;
      PH_FINISH:  code = PH_CODE_FINISH;
      PH_DELAY:   code = PH_CODE_DELAY;
      default:    code = PH_CODE_SELECT;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/spms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the transmit store.
`timescale 1ns / 1ps

module spms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read ports, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/spms_seq.sv =====
// Poll sequencer state and its one-request update logic.
// Depends on spms_pkg; drives transmit store requests toward spms_txbuf.
`timescale 1ns / 1ps

module spms_seq #(
  parameter int BUFFER_DEPTH = spms_pkg::BUFFER_DEPTH_DEF,
  parameter int SLAVE_COUNT  = spms_pkg::SLAVE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  spms_pkg::req_item_t    req,
  input  spms_pkg::cfg_t         cfg,
  output spms_pkg::rsp_item_t    rsp_next,
  output spms_pkg::store_req_t   store
);

  localparam int SW = (SLAVE_COUNT > 1) ? $clog2(SLAVE_COUNT) : 1;
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int TW = (AW + 1 > 9) ? AW + 1 : 9;

  spms_pkg::phase_t phase, phase_next;
  logic [15:0]   delay_count, delay_count_next;
  logic [SW-1:0] slave_index, slave_index_next;
  logic [1:0]    retry_count, retry_count_next;
  logic [8:0]    byte_position, byte_position_next;
  logic [1:0]    transfer_tally, transfer_tally_next;
  logic [3:0]    select_lines, select_lines_next;

  logic [8:0] byte_total;
  logic [8:0] pos_inc;
  logic       fin;
  logic       fin_abort;
  logic       push_v;
  logic       tx_v;

  // Bytes per poll, capped at the store depth
  assign byte_total = (TW'(cfg.bytes_per_transfer) < TW'(BUFFER_DEPTH)) ?
                      cfg.bytes_per_transfer : 9'(BUFFER_DEPTH);
  assign pos_inc = byte_position + 9'd1;

  // Compute the state after one request
  always_comb begin
    phase_next          = phase;
    delay_count_next    = delay_count;
    slave_index_next    = slave_index;
    retry_count_next    = retry_count;
    byte_position_next  = byte_position;
    transfer_tally_next = transfer_tally;
    select_lines_next   = select_lines;
    store               = '0;
    fin                 = 1'b0;
    fin_abort           = 1'b0;
    push_v              = 1'b0;

    case (req.operation)
      spms_pkg::OP_ADVANCE: begin
        case (phase)
          spms_pkg::PH_SELECT: begin
            select_lines_next = ~(4'b0001 << slave_index);
            delay_count_next  = cfg.select_delay;
            if (transfer_tally >= 2'd2) begin
              store.clear         = 1'b1;
              transfer_tally_next = 2'd0;
            end
            phase_next = spms_pkg::PH_WAIT;
          end
          spms_pkg::PH_WAIT: begin
            if (delay_count == 16'd0) begin
              byte_position_next = 9'd0;
              phase_next         = spms_pkg::PH_SEND;
            end
          end
          spms_pkg::PH_SEND: begin
            if (byte_total == 9'd0) begin
              fin = 1'b1;
            end
          end
          spms_pkg::PH_RELEASE: begin
            if (delay_count == 16'd0) begin
              select_lines_next = select_lines | (4'b0001 << slave_index);
              phase_next        = spms_pkg::PH_FINISH;
            end
          end
          spms_pkg::PH_FINISH: begin
            retry_count_next = 2'd0;
            slave_index_next = (slave_index == SW'(SLAVE_COUNT - 1)) ?
                               '0 : slave_index + SW'(1);
            delay_count_next = cfg.gap_delay;
            phase_next       = spms_pkg::PH_DELAY;
          end
          spms_pkg::PH_DELAY: begin
            if (delay_count == 16'd0) begin
              select_lines_next = 4'hF;
              phase_next        = spms_pkg::PH_SELECT;
            end
          end
          default: begin
            select_lines_next = 4'hF;
            phase_next        = spms_pkg::PH_SELECT;
          end
        endcase
      end
      spms_pkg::OP_TICK: begin
        if (delay_count != 16'd0) begin
          delay_count_next = delay_count - 16'd1;
        end
      end
      spms_pkg::OP_RX: begin
        if (phase == spms_pkg::PH_SEND && byte_position < byte_total) begin
          if (byte_position == 9'd0 && req.rx_byte == spms_pkg::ABORT_BYTE) begin
            fin       = 1'b1;
            fin_abort = 1'b1;
          end else begin
            push_v             = (req.rx_byte != 8'd0);
            byte_position_next = pos_inc;
            fin                = (pos_inc >= byte_total);
          end
        end
      end
      spms_pkg::OP_LOAD: begin
        store.load_en    = 1'b1;
        store.load_index = req.load_index;
        store.load_value = req.load_value;
      end
      default: begin
      end
    endcase

    // Close the poll: retry on abort while allowed, else release
    if (fin) begin
      if (transfer_tally != 2'd3) begin
        transfer_tally_next = transfer_tally + 2'd1;
      end
      if (fin_abort && retry_count < cfg.retry_limit) begin
        retry_count_next = retry_count + 2'd1;
        delay_count_next = cfg.retry_delay;
        phase_next       = spms_pkg::PH_DELAY;
      end else begin
        delay_count_next = cfg.release_delay;
        phase_next       = spms_pkg::PH_RELEASE;
      end
    end

    // Fetch the byte to send next
    tx_v           = (phase_next == spms_pkg::PH_SEND) && (byte_position_next < byte_total);
    store.read_en  = tx_v;
    store.read_pos = byte_position_next;

    rsp_next.chip_select_n = select_lines_next;
    rsp_next.tx_valid      = tx_v;
    rsp_next.tx_byte       = 8'd0;
    rsp_next.push_valid    = push_v;
    rsp_next.push_byte     = push_v ? req.rx_byte : 8'd0;
    rsp_next.phase         = spms_pkg::phase_code(phase_next);
    rsp_next.current_slave = 2'(slave_index_next);
  end

  // Commit the state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= spms_pkg::PH_SELECT;
      delay_count    <= 16'd0;
      slave_index    <= '0;
      retry_count    <= 2'd0;
      byte_position  <= 9'd0;
      transfer_tally <= 2'd0;
      select_lines   <= 4'hF;
    end else if (step) begin
      phase          <= phase_next;
      delay_count    <= delay_count_next;
      slave_index    <= slave_index_next;
      retry_count    <= retry_count_next;
      byte_position  <= byte_position_next;
      transfer_tally <= transfer_tally_next;
      select_lines   <= select_lines_next;
    end
  end

endmodule

// ===== rtl/spms_txbuf.sv =====
// Transmit store: RAM with a generation tag per byte, fill pass and bypass.
// Depends on spms_pkg and spms_ram.
`timescale 1ns / 1ps

module spms_txbuf #(
  parameter int BUFFER_DEPTH = spms_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  spms_pkg::store_req_t store,
  output logic                 busy,
  output logic [7:0]           tx_byte
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int LW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int XW = (AW > 9) ? AW : 9;
  localparam int GW = spms_pkg::GEN_W;
  localparam int MW = GW + 8;

  logic [GW-1:0] cur_gen, gen_next;
  logic          sweeping;
  logic [AW-1:0] sweep_cnt;
  logic          sweep_index;
  logic [GW-1:0] rd_gen;
  logic          fwd;
  logic [7:0]    fwd_data;

  logic          load_ok;
  logic          load_we;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] rd_addr;
  logic          re;
  logic          we;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic [MW-1:0] rdata;

  assign load_ok   = LW'(store.load_index) < LW'(BUFFER_DEPTH);
  assign load_we   = step && store.load_en && load_ok;
  assign load_addr = AW'(LW'(store.load_index));
  assign rd_addr   = AW'(XW'(store.read_pos));
  assign re        = step && store.read_en;
  assign gen_next  = cur_gen + GW'(store.clear && step);

  // Fill pass has the write port; otherwise loads write
  assign we    = sweeping || load_we;
  assign waddr = sweeping ? sweep_cnt : load_addr;
  assign wdata = sweeping ? {cur_gen, (sweep_index ? 8'(sweep_cnt) : 8'd0)}
                          : {cur_gen, store.load_value};

  spms_ram #(
    .WIDTH (MW),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Track generation and run the fill pass after reset and on tag wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_gen     <= '0;
      sweeping    <= 1'b1;
      sweep_cnt   <= '0;
      sweep_index <= 1'b1;
    end else if (sweeping) begin
      sweep_cnt <= sweep_cnt + AW'(1);
      if (sweep_cnt == AW'(BUFFER_DEPTH - 1)) begin
        sweeping <= 1'b0;
      end
    end else if (step && store.clear) begin
      cur_gen <= gen_next;
      if (cur_gen == {GW{1'b1}}) begin
        sweeping    <= 1'b1;
        sweep_cnt   <= '0;
        sweep_index <= 1'b0;
      end
    end
  end

  // Hold read tag and same-cycle write bypass alongside the RAM data
  always_ff @(posedge clk) begin
    if (re) begin
      rd_gen   <= gen_next;
      fwd      <= load_we && (load_addr == rd_addr);
      fwd_data <= store.load_value;
    end
  end

  assign busy    = sweeping;
  assign tx_byte = fwd ? fwd_data :
                   ((rdata[MW-1:8] == rd_gen) ? rdata[7:0] : 8'd0);

endmodule

// ===== rtl/spi_multi_slave_poll_sequencer_core.sv =====
// SPI multi-slave poll sequencer core, top level.
// Request channel (req_valid, req_stall, req_item): each request is one event,
// an advance step, a millisecond tick, a received byte or a transmit store load.
// Response channel (rsp_valid, rsp_stall, rsp_item): exactly one response per
// request, in order, showing chip selects, phase and slave after the event, the
// next byte to shift out and any received byte pushed to the FIFO.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register
// writes, always ready; write only while no request is in flight.
// The response passes through the internal stage, which waits for the registered read
// of the transmit store RAM, then the output register; one request is accepted per
// cycle while req_stall is low. After reset the transmit store fill pass runs with
// req_stall high; the same pass reruns once every 4096 store clears.
// When rsp_stall holds the response, one more request is taken into the
// internal stage, then req_stall rises until the response is taken.
// Depends on spms_pkg, spms_seq, spms_txbuf, spms_ram.
`timescale 1ns / 1ps

module spi_multi_slave_poll_sequencer_core #(
  parameter int BUFFER_DEPTH = spms_pkg::BUFFER_DEPTH_DEF,
  parameter int SLAVE_COUNT  = spms_pkg::SLAVE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  spms_pkg::req_item_t               req_item,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output spms_pkg::rsp_item_t               rsp_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  spms_pkg::cfg_t       cfg;
  spms_pkg::rsp_item_t  rsp_next;
  spms_pkg::store_req_t store;
  spms_pkg::rsp_item_t  p1_item;
  spms_pkg::rsp_item_t  merged;
  logic                 p1_valid;
  logic                 p1_move;
  logic                 accept;
  logic                 buf_busy;
  logic [7:0]           buf_tx_byte;

  // Accept unless filling the store or both stages are held
  assign req_stall = buf_busy || (p1_valid && rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign p1_move   = p1_valid && (!rsp_valid || !rsp_stall);
  assign cfg_ready = 1'b1;

  spms_seq #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SLAVE_COUNT  (SLAVE_COUNT)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (accept),
    .req      (req_item),
    .cfg      (cfg),
    .rsp_next (rsp_next),
    .store    (store)
  );

  spms_txbuf #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_txbuf (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .store   (store),
    .busy    (buf_busy),
    .tx_byte (buf_tx_byte)
  );

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_transfer <= spms_pkg::BYTES_PER_TRANSFER_RST;
      cfg.retry_limit        <= spms_pkg::RETRY_LIMIT_RST;
      cfg.select_delay       <= spms_pkg::SELECT_DELAY_RST;
      cfg.retry_delay        <= spms_pkg::RETRY_DELAY_RST;
      cfg.release_delay      <= spms_pkg::RELEASE_DELAY_RST;
      cfg.gap_delay          <= spms_pkg::GAP_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spms_pkg::CFG_BYTES_PER_TRANSFER: cfg.bytes_per_transfer <= cfg_data[8:0];
        spms_pkg::CFG_RETRY_LIMIT:        cfg.retry_limit        <= cfg_data[1:0];
        spms_pkg::CFG_SELECT_DELAY:       cfg.select_delay       <= cfg_data;
        spms_pkg::CFG_RETRY_DELAY:        cfg.retry_delay        <= cfg_data;
        spms_pkg::CFG_RELEASE_DELAY:      cfg.release_delay      <= cfg_data;
        spms_pkg::CFG_GAP_DELAY:          cfg.gap_delay          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold the result of the accepted request while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_item <= rsp_next;
    end
  end

  // Merge the store byte into the response
  always_comb begin
    merged         = p1_item;
    merged.tx_byte = p1_item.tx_valid ? buf_tx_byte : 8'd0;
  end

  // Output register: load on move, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (p1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      rsp_item <= merged;
    end
  end

endmodule

// ===== rtl/spms_checker.sv =====
// Port-level checks of the poll sequencer core, bound to the top level.
// Depends on spms_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "spi_multi_slave_poll_sequencer_core_defines.svh"

module spms_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input spms_pkg::rsp_item_t rsp_item
);

  // Held response stays put
  `SPMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

  // A byte to send only exists in the send phase
  `SPMS_ASSERT_SAME(a_tx_in_send, rsp_valid && rsp_item.tx_valid, rsp_item.phase == spms_pkg::PH_CODE_SEND)

  // Unused byte fields read zero
  `SPMS_ASSERT_SAME(a_idle_bytes_zero, rsp_valid, (rsp_item.tx_valid || rsp_item.tx_byte == 8'd0) && (rsp_item.push_valid || rsp_item.push_byte == 8'd0))

  // Zero bytes are never pushed
  `SPMS_ASSERT_SAME(a_push_nonzero, rsp_valid && rsp_item.push_valid, rsp_item.push_byte != 8'd0)

  // At most one slave selected
  `SPMS_ASSERT_SAME(a_one_select, rsp_valid, $countones(~rsp_item.chip_select_n) <= 1)

endmodule

bind spi_multi_slave_poll_sequencer_core spms_checker u_spms_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

// ===== sim/tb_top.sv =====
// Self-checking bench for the SPI multi-slave poll sequencer core.
// Tracks the poll sequence in a scoreboard class and checks every response.
// Depends on spms_pkg and spi_multi_slave_poll_sequencer_core.
`timescale 1ns / 1ps

import spms_pkg::*;

// Predicts one status per request and checks responses in order
class poll_sequence_tracker;
  // register copies
  logic [8:0]  n_bytes;
  logic [1:0]  retry_max;
  logic [15:0] sel_dly;
  logic [15:0] rty_dly;
  logic [15:0] rel_dly;
  logic [15:0] gap_dly;
  // sequencer state
  logic [2:0]  phase;
  logic [15:0] ticks_left;
  logic [1:0]  slave;
  logic [1:0]  retries;
  logic [8:0]  pos;
  logic [1:0]  tally;
  logic [3:0]  cs_n;
  logic [7:0]  store [256];

  rsp_item_t status_due [$];
  string field_name [7] = '{"chip_select_n", "tx_valid", "tx_byte", "push_valid",
                            "push_byte", "phase", "current_slave"};
  int requests, checked, errors, pushes, retried, gave_up, clears;

  function new();
    n_bytes    = BYTES_PER_TRANSFER_RST;
    retry_max  = RETRY_LIMIT_RST;
    sel_dly    = SELECT_DELAY_RST;
    rty_dly    = RETRY_DELAY_RST;
    rel_dly    = RELEASE_DELAY_RST;
    gap_dly    = GAP_DELAY_RST;
    phase      = PH_CODE_SELECT;
    ticks_left = '0;
    slave      = '0;
    retries    = '0;
    pos        = '0;
    tally      = '0;
    cs_n       = 4'hF;
    foreach (store[i]) store[i] = i[7:0];
  endfunction

  // Bytes per poll, clamped to the store size
  function logic [8:0] byte_total();
    return (n_bytes > 9'd256) ? 9'd256 : n_bytes;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      CFG_BYTES_PER_TRANSFER: n_bytes   = data[8:0];
      CFG_RETRY_LIMIT:        retry_max = data[1:0];
      CFG_SELECT_DELAY:       sel_dly   = data;
      CFG_RETRY_DELAY:        rty_dly   = data;
      CFG_RELEASE_DELAY:      rel_dly   = data;
      CFG_GAP_DELAY:          gap_dly   = data;
      default: ;
    endcase
  endfunction

  // End a poll: retry an abort while retries remain, else go to release
  function void close_poll(bit aborted);
    if (tally < 2'd3) tally = tally + 2'd1;
    if (aborted && retries < retry_max) begin
      retries    = retries + 2'd1;
      ticks_left = rty_dly;
      phase      = PH_CODE_DELAY;
      retried++;
    end else begin
      if (aborted) gave_up++;
      ticks_left = rel_dly;
      phase      = PH_CODE_RELEASE;
    end
  endfunction

  // Apply one accepted request and queue the status it should produce
  function void note_request(req_item_t r);
    rsp_item_t s;
    s = '0;
    requests++;
    case (r.operation)
      OP_ADVANCE: begin
        case (phase)
          PH_CODE_SELECT: begin
            cs_n       = ~(4'b0001 << slave);
            ticks_left = sel_dly;
            if (tally >= 2'd2) begin
              foreach (store[i]) store[i] = 8'h00;
              tally = '0;
              clears++;
            end
            phase = PH_CODE_WAIT;
          end
          PH_CODE_WAIT: begin
            if (ticks_left == 0) begin
              pos   = '0;
              phase = PH_CODE_SEND;
            end
          end
          PH_CODE_SEND: begin
            if (byte_total() == 0) close_poll(1'b0);
          end
          PH_CODE_RELEASE: begin
            if (ticks_left == 0) begin
              cs_n[slave] = 1'b1;
              phase       = PH_CODE_FINISH;
            end
          end
          PH_CODE_FINISH: begin
            retries    = '0;
            slave      = slave + 2'd1;
            ticks_left = gap_dly;
            phase      = PH_CODE_DELAY;
          end
          default: begin
            if (ticks_left == 0) begin
              cs_n  = 4'hF;
              phase = PH_CODE_SELECT;
            end
          end
        endcase
      end
      OP_TICK: begin
        if (ticks_left != 0) ticks_left = ticks_left - 16'd1;
      end
      OP_RX: begin
        if (phase == PH_CODE_SEND && pos < byte_total()) begin
          if (pos == 0 && r.rx_byte == ABORT_BYTE) begin
            close_poll(1'b1);
          end else begin
            if (r.rx_byte != 8'h00) begin
              s.push_valid = 1'b1;
              s.push_byte  = r.rx_byte;
              pushes++;
            end
            pos = pos + 9'd1;
            if (pos >= byte_total()) close_poll(1'b0);
          end
        end
      end
      default: store[r.load_index] = r.load_value;
    endcase
    if (phase == PH_CODE_SEND && pos < byte_total()) begin
      s.tx_valid = 1'b1;
      s.tx_byte  = store[pos[7:0]];
    end
    s.chip_select_n = cs_n;
    s.phase         = phase;
    s.current_slave = slave;
    status_due.push_back(s);
  endfunction

  // Compare one accepted response with the oldest predicted status
  function void check_status(rsp_item_t got);
    rsp_item_t  want;
    logic [7:0] w [7];
    logic [7:0] g [7];
    if (status_due.size() == 0) begin
      $display("%0t: response with no request pending: %p", $time, got);
      errors++;
      return;
    end
    want = status_due.pop_front();
    checked++;
    w = '{8'(want.chip_select_n), 8'(want.tx_valid), want.tx_byte, 8'(want.push_valid),
          want.push_byte, 8'(want.phase), 8'(want.current_slave)};
    g = '{8'(got.chip_select_n), 8'(got.tx_valid), got.tx_byte, 8'(got.push_valid),
          got.push_byte, 8'(got.phase), 8'(got.current_slave)};
    for (int i = 0; i < 7; i++) begin
      if (g[i] !== w[i]) begin
        $display("%0t: %s expected %0h actual %0h", $time, field_name[i], w[i], g[i]);
        errors++;
      end
    end
  endfunction
endclass

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LATENCY_PAD    = 8;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_item_t             req_item  = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_item_t             rsp_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  poll_sequence_tracker tracker;
  int req_calm  = 0;
  int rsp_calm  = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int reg_sets  = 0;

  spi_multi_slave_poll_sequencer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, a few long, with calm stretches
  function automatic int idle_len(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_item_t req_of(logic [1:0] op, logic [7:0] rx, logic [7:0] idx,
                                       logic [7:0] val);
    req_item_t r;
    r.operation  = op;
    r.rx_byte    = rx;
    r.load_index = idx;
    r.load_value = val;
    return r;
  endfunction

  // Offer one request after a random gap, hold it until taken
  task automatic send_step(input req_item_t r);
    int gap;
    gap = idle_len(req_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_item  <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    tracker.note_request(r);
  endtask

  // Drain, rewrite every register, then run a mostly well-formed poll stream
  task automatic run_phase(input int bytes, input int limit, input int sel, input int rty,
                           input int rel, input int gap, input int n_items,
                           input int abort_pct);
    logic [15:0] v [1 << CFG_IDX_W];
    logic [8:0]  nb;
    req_item_t   r;
    int          roll;
    while (tracker.status_due.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
    // keep a poll in progress from stalling on a count below its position
    nb = bytes[8:0];
    if (tracker.phase == PH_CODE_SEND && nb != 0 &&
        ((nb > 9'd256) ? 9'd256 : nb) <= tracker.pos)
      nb = tracker.pos + 9'd1;
    v[CFG_BYTES_PER_TRANSFER] = {7'($urandom), nb};
    v[CFG_RETRY_LIMIT]        = {14'($urandom), 2'(limit)};
    v[CFG_SELECT_DELAY]       = 16'(sel);
    v[CFG_RETRY_DELAY]        = 16'(rty);
    v[CFG_RELEASE_DELAY]      = 16'(rel);
    v[CFG_GAP_DELAY]          = 16'(gap);
    for (int i = CFG_GAP_DELAY + 1; i < (1 << CFG_IDX_W); i++) v[i] = 16'($urandom);
    cfg_valid <= 1'b1;
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= v[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.set_reg(CFG_IDX_W'(i), v[i]);
    end
    cfg_valid <= 1'b0;
    reg_sets++;
    // follow the sequence most of the time, with loads and noise mixed in
    repeat (n_items) begin
      r = $bits(req_item_t)'($urandom);
      roll = $urandom_range(99);
      if (roll < 6) begin
        r.operation = OP_LOAD;
      end else if (roll >= 14) begin
        if (tracker.phase == PH_CODE_SEND && tracker.pos < tracker.byte_total()) begin
          r.operation = OP_RX;
          if (tracker.pos == 0 && $urandom_range(99) < abort_pct) r.rx_byte = ABORT_BYTE;
          else if ($urandom_range(7) == 0) r.rx_byte = 8'h00;
        end else if (tracker.ticks_left != 0) begin
          r.operation = OP_TICK;
        end else begin
          r.operation = OP_ADVANCE;
        end
      end
      send_step(r);
    end
    req_valid <= 1'b0;
  endtask

  // Check responses and stall the response side at random
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_status(rsp_item);
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      hold_left = idle_len(rsp_calm);
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Drop the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed walk through one aborted poll and its retry at reset settings
    send_step(req_of(OP_RX,      ABORT_BYTE, 8'h00, 8'h00)); // byte outside send
    send_step(req_of(OP_TICK,    8'h00, 8'hFF, 8'hFF));      // tick with delay at zero
    send_step(req_of(OP_LOAD,    8'hFF, 8'h00, 8'hFF));
    send_step(req_of(OP_LOAD,    8'h00, 8'hFF, 8'h00));
    send_step(req_of(OP_LOAD,    8'h5A, 8'h01, 8'hA5));
    send_step(req_of(OP_ADVANCE, 8'h00, 8'h00, 8'h00));      // select slave 0
    send_step(req_of(OP_ADVANCE, 8'hFF, 8'hFF, 8'hFF));      // hold in wait
    send_step(req_of(OP_TICK,    8'h00, 8'h00, 8'h00));
    send_step(req_of(OP_TICK,    8'h00, 8'h00, 8'h00));      // stays at zero
    send_step(req_of(OP_ADVANCE, 8'h00, 8'h00, 8'h00));      // enter send
    send_step(req_of(OP_ADVANCE, 8'h00, 8'h00, 8'h00));      // no effect while sending
    send_step(req_of(OP_LOAD,    8'h00, 8'h00, 8'h3C));      // rewrite the byte on the wire
    send_step(req_of(OP_RX,      ABORT_BYTE, 8'h00, 8'h00)); // abort on first byte
    send_step(req_of(OP_ADVANCE, 8'h00, 8'h00, 8'h00));
    send_step(req_of(OP_TICK,    8'h00, 8'h00, 8'h00));
    send_step(req_of(OP_TICK,    8'h00, 8'h00, 8'h00));
    send_step(req_of(OP_ADVANCE, 8'h00, 8'h00, 8'h00));      // back to select
    send_step(req_of(OP_ADVANCE, 8'h00, 8'h00, 8'h00));
    send_step(req_of(OP_TICK,    8'h00, 8'h00, 8'h00));
    send_step(req_of(OP_ADVANCE, 8'h00, 8'h00, 8'h00));      // retry enters send
    send_step(req_of(OP_RX,      8'h00, 8'h00, 8'h00));      // zero byte, no push
    send_step(req_of(OP_RX,      ABORT_BYTE, 8'h00, 8'h00)); // 0xFF later is data
    send_step(req_of(OP_RX,      8'h01, 8'h00, 8'h00));
    req_valid <= 1'b0;

    // register settings: short polls first, extremes along the way
    run_phase(4,   3, 1, 2, 1, 3, 220, 30);
    run_phase(1,   0, 0, 0, 0, 0, 200, 40);
    run_phase(0,   2, 2, 1, 0, 1, 120, 30);
    run_phase(3,   3, 0, 1, 2, 0, 220, 75);
    run_phase(511, 1, 1, 0, 1, 2, 330, 10);
    run_phase($urandom_range(1, 8), $urandom_range(0, 3), $urandom_range(0, 5),
              $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5), 250, 30);
    run_phase($urandom_range(1, 8), $urandom_range(0, 3), $urandom_range(0, 5),
              $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5), 200, 50);
    // longest delays last, since they leave the counter far from zero
    run_phase(1, 3, 65535, 65535, 65535, 65535, 60, 30);

    while (tracker.status_due.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
    $display("Ran %0d requests under %0d register settings, %0d responses compared.",
             tracker.requests, reg_sets, tracker.checked);
    $display("Saw %0d FIFO pushes, %0d retries, %0d aborts past the limit, %0d store clears.",
             tracker.pushes, tracker.retried, tracker.gave_up, tracker.clears);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
